/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files that carry concurrent checks.
// Depends on nothing; each macro takes a label, clock, active-low reset and message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bee_pkg.sv */
// Shared types, constants and functions of the binary edge extraction block.
// Depends on nothing; used by bee_proc and the top level.
package bee_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int X_W   = $clog2(MAX_WIDTH);
    localparam int Y_W   = $clog2(MAX_HEIGHT);
    localparam int A_W   = X_W + Y_W;
    localparam int DEPTH = 1 << A_W;
    localparam int CFG_W = 9;
    localparam int XY_W  = (X_W > Y_W) ? X_W : Y_W;
    localparam int DIM_W = (CFG_W > XY_W + 2) ? CFG_W : XY_W + 2;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_PROCESS = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;

    localparam logic [31:0] PIX_WHITE = 32'h00ff_ffff;
    localparam logic [31:0] PIX_ALPHA = 32'hff00_0000;

    localparam logic [3:0] NB_COUNT_EDGE = 4'd5;
    localparam logic [3:0] NB_COUNT_THIN = 4'd9;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  pos_x;
        logic [7:0]  pos_y;
        logic [31:0] pixel_value;
    } t_in;

    typedef struct packed {
        logic edge_bit;
        logic done_res;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROC,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        PS_IDLE,
        PS_PIX,
        PS_GATHER,
        PS_WRITE,
        PS_NEXT,
        PS_THIN_INIT,
        PS_DONE
    } t_pstate;

    typedef struct packed {
        logic           solid_re;
        logic           edge_re;
        logic [A_W-1:0] rd_addr;
        logic           edge_we;
        logic [A_W-1:0] wr_addr;
        logic           wr_bit;
        logic           done;
    } t_proc_req;

    typedef struct packed {
        logic xm;
        logic xp;
        logic ym;
        logic yp;
    } t_step;

    function automatic logic is_solid(logic [31:0] v);
        return (v != 32'd0) && (v != PIX_WHITE) && (v != PIX_ALPHA);
    endfunction

    // Neighbor order: edge pass c,n,w,e,s; thinning pass c,e,n,w,s,ne,nw,sw,se.
    function automatic t_step nb_step(logic thin, logic [3:0] k);
        t_step s;
        s = '0;
        if (!thin) begin
            unique case (k)
                4'd1: s.ym = 1'b1;
                4'd2: s.xm = 1'b1;
                4'd3: s.xp = 1'b1;
                4'd4: s.yp = 1'b1;
                default: s = '0;
            endcase
        end else begin
            unique case (k)
                4'd1: s.xp = 1'b1;
                4'd2: s.ym = 1'b1;
                4'd3: s.xm = 1'b1;
                4'd4: s.yp = 1'b1;
                4'd5: begin s.xp = 1'b1; s.ym = 1'b1; end
                4'd6: begin s.xm = 1'b1; s.ym = 1'b1; end
                4'd7: begin s.xm = 1'b1; s.yp = 1'b1; end
                4'd8: begin s.xp = 1'b1; s.yp = 1'b1; end
                default: s = '0;
            endcase
        end
        return s;
    endfunction

    function automatic logic thin_clear(logic [8:0] nb);
        logic       e, n, w, s, ne, nw, sw, se;
        logic [3:0] chi;
        e  = nb[1];
        n  = nb[2];
        w  = nb[3];
        s  = nb[4];
        ne = nb[5];
        nw = nb[6];
        sw = nb[7];
        se = nb[8];
        chi = 4'(e ^ n) + 4'(n ^ w) + 4'(w ^ s) + 4'(s ^ e)
            + {2'b00, (~e & ne & ~n), 1'b0} + {2'b00, (~n & nw & ~w), 1'b0}
            + {2'b00, (~w & sw & ~s), 1'b0} + {2'b00, (~s & se & ~e), 1'b0};
        return (chi == 4'd2) && ((w && s) || (w && n) || (e && s) || (e && n));
    endfunction

endpackage

/* rtl/bee_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing; width and depth are parameters.
module bee_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bee_proc.sv */
// Frame sequencer: builds the edge map from the solid store, then thins it in place.
// Depends on bee_pkg; drives the read ports of both stores and the write port of the edge store through a struct.
module bee_proc (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [bee_pkg::DIM_W-1:0] i_eff_w,
    input  logic [bee_pkg::DIM_W-1:0] i_eff_h,
    input  logic                      i_solid_rdata,
    input  logic                      i_edge_rdata,
    output bee_pkg::t_proc_req        o_req
);

    bee_pkg::t_pstate            r_state, n_state;
    logic                        r_thin, n_thin;
    logic                        r_inner, n_inner;
    logic [bee_pkg::X_W-1:0]     r_x, n_x;
    logic [bee_pkg::Y_W-1:0]     r_y, n_y;
    logic [3:0]                  r_k, n_k;
    logic [8:0]                  r_nb, n_nb;

    logic [bee_pkg::DIM_W-1:0]   x_ext, y_ext;
    logic                        interior;
    logic                        rdata;
    logic [3:0]                  nb_last;
    logic [3:0]                  k_prev;
    bee_pkg::t_step              step;
    logic [bee_pkg::X_W-1:0]     nx;
    logic [bee_pkg::Y_W-1:0]     ny;
    logic                        empty_frame;
    logic                        small_frame;

    always_comb begin
        x_ext       = bee_pkg::DIM_W'(r_x);
        y_ext       = bee_pkg::DIM_W'(r_y);
        interior    = (r_x != '0) && (r_y != '0)
                   && (x_ext + 1'b1 < i_eff_w) && (y_ext + 1'b1 < i_eff_h);
        rdata       = r_thin ? i_edge_rdata : i_solid_rdata;
        nb_last     = r_thin ? bee_pkg::NB_COUNT_THIN : bee_pkg::NB_COUNT_EDGE;
        k_prev      = r_k - 4'd1;
        step        = bee_pkg::nb_step(r_thin, r_k);
        nx          = step.xm ? r_x - 1'b1 : (step.xp ? r_x + 1'b1 : r_x);
        ny          = step.ym ? r_y - 1'b1 : (step.yp ? r_y + 1'b1 : r_y);
        empty_frame = (i_eff_w == '0) || (i_eff_h == '0);
        small_frame = (i_eff_w < bee_pkg::DIM_W'(3)) || (i_eff_h < bee_pkg::DIM_W'(3));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bee_pkg::PS_IDLE: begin
                if (i_start) begin
                    n_state = empty_frame ? bee_pkg::PS_THIN_INIT : bee_pkg::PS_PIX;
                end
            end
            bee_pkg::PS_PIX: begin
                n_state = (!r_thin && !interior) ? bee_pkg::PS_WRITE : bee_pkg::PS_GATHER;
            end
            bee_pkg::PS_GATHER: begin
                priority if (r_thin && (r_k == 4'd1) && !rdata) begin
                    n_state = bee_pkg::PS_NEXT;
                end else if (r_k == nb_last) begin
                    n_state = bee_pkg::PS_WRITE;
                end else begin
                    n_state = bee_pkg::PS_GATHER;
                end
            end
            bee_pkg::PS_WRITE: n_state = bee_pkg::PS_NEXT;
            bee_pkg::PS_NEXT: begin
                if (!r_thin) begin
                    priority if (y_ext + 1'b1 < i_eff_h) begin
                        n_state = bee_pkg::PS_PIX;
                    end else if (x_ext + 1'b1 < i_eff_w) begin
                        n_state = bee_pkg::PS_PIX;
                    end else begin
                        n_state = bee_pkg::PS_THIN_INIT;
                    end
                end else begin
                    priority if (y_ext + 2'd2 < i_eff_h) begin
                        n_state = bee_pkg::PS_PIX;
                    end else if (x_ext + 2'd2 < i_eff_w) begin
                        n_state = bee_pkg::PS_PIX;
                    end else begin
                        n_state = bee_pkg::PS_DONE;
                    end
                end
            end
            bee_pkg::PS_THIN_INIT: begin
                n_state = small_frame ? bee_pkg::PS_DONE : bee_pkg::PS_PIX;
            end
            bee_pkg::PS_DONE: n_state = bee_pkg::PS_IDLE;
            default: n_state = bee_pkg::PS_IDLE;
        endcase
    end

    always_comb begin
        n_thin  = r_thin;
        n_inner = r_inner;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_nb    = r_nb;
        unique case (r_state)
            bee_pkg::PS_IDLE: begin
                n_thin = 1'b0;
                n_x    = '0;
                n_y    = '0;
            end
            bee_pkg::PS_PIX: begin
                n_inner = interior;
                n_k     = '0;
            end
            bee_pkg::PS_GATHER: begin
                n_k = r_k + 4'd1;
                if (r_k != '0) begin
                    n_nb[k_prev] = rdata;
                end
            end
            bee_pkg::PS_NEXT: begin
                if (!r_thin) begin
                    if (y_ext + 1'b1 < i_eff_h) begin
                        n_y = r_y + 1'b1;
                    end else begin
                        n_y = '0;
                        n_x = r_x + 1'b1;
                    end
                end else begin
                    if (y_ext + 2'd2 < i_eff_h) begin
                        n_y = r_y + 1'b1;
                    end else begin
                        n_y = bee_pkg::Y_W'(1);
                        n_x = r_x + 1'b1;
                    end
                end
            end
            bee_pkg::PS_THIN_INIT: begin
                n_thin = 1'b1;
                n_x    = bee_pkg::X_W'(1);
                n_y    = bee_pkg::Y_W'(1);
            end
            default: begin
                n_thin = r_thin;
            end
        endcase
    end

    always_comb begin
        o_req          = '0;
        o_req.rd_addr  = {ny, nx};
        o_req.wr_addr  = {r_y, r_x};
        unique case (r_state)
            bee_pkg::PS_GATHER: begin
                o_req.solid_re = !r_thin && (r_k < nb_last);
                o_req.edge_re  = r_thin && (r_k < nb_last);
            end
            bee_pkg::PS_WRITE: begin
                o_req.edge_we = r_thin ? bee_pkg::thin_clear(r_nb) : 1'b1;
                o_req.wr_bit  = !r_thin && r_inner && r_nb[0]
                             && !(r_nb[1] && r_nb[2] && r_nb[3] && r_nb[4]);
            end
            bee_pkg::PS_DONE: o_req.done = 1'b1;
            default: o_req.done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bee_pkg::PS_IDLE;
            r_thin  <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_thin  <= n_thin;
            r_k     <= n_k;
        end
        r_inner <= n_inner;
        r_x     <= n_x;
        r_y     <= n_y;
        r_nb    <= n_nb;
    end

endmodule

/* rtl/binary_edge_extract_thin_unit.sv */
// Top level of the binary edge extraction and thinning block.
// Depends on bee_pkg, bee_ram, bee_proc and assert_macros.svh.
//
// Usage:
//   The input channel carries one command beat: write a source pixel, run the
//   edge extraction over the frame, or read one edge bit. Every beat yields
//   exactly one result beat on the output channel (edge bit and done flag).
//   The frame size registers are written through the plain configuration port;
//   the user must write them only while the block is idle; the block does not enforce it.
//   A write or a read loads its result once the result register is free, at the
//   edge that returns the controller to idle, and no new beat is taken before
//   then. The read data comes from the registered read of the edge store.
//   A process beat walks the frame twice through the single read port of each
//   store: the edge pass reads the centre and four neighbours of each interior
//   pixel and writes border pixels directly, then the thinning pass reads the
//   centre and eight neighbours of each set interior pixel, skipping clear ones.
//   Reset returns the controller to idle, empties the result register and sets
//   both frame dimensions to 256. The pixel stores are not cleared.
//   While the receiver stalls, the result beat holds; the block may take one
//   more command and finish it, then waits until the result register drains.
module binary_edge_extract_thin_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bee_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bee_pkg::t_out             o_out_data,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bee_pkg::CFG_W-1:0] i_cfg_data
);

`include "assert_macros.svh"

    bee_pkg::t_state              r_state, n_state;
    logic [1:0]                   r_op;
    logic                         r_inside;
    logic                         r_out_valid, n_out_valid;
    bee_pkg::t_out                r_out;
    logic [bee_pkg::CFG_W-1:0]    r_frame_w, r_frame_h;

    logic                         in_accept;
    logic                         out_free;
    logic                         load_out;
    logic [bee_pkg::DIM_W-1:0]    eff_w, eff_h;
    logic [bee_pkg::DIM_W-1:0]    px_ext, py_ext;
    logic [bee_pkg::A_W-1:0]      pos_addr;
    logic                         solid_we;
    logic                         edge_re;
    logic                         edge_we;
    logic [bee_pkg::A_W-1:0]      edge_raddr;
    logic                         solid_rdata, edge_rdata;
    logic                         proc_start;
    bee_pkg::t_proc_req           proc_req;

    always_comb begin
        eff_w = (bee_pkg::DIM_W'(r_frame_w) >= bee_pkg::DIM_W'(bee_pkg::MAX_WIDTH))
              ? bee_pkg::DIM_W'(bee_pkg::MAX_WIDTH) : bee_pkg::DIM_W'(r_frame_w);
        eff_h = (bee_pkg::DIM_W'(r_frame_h) >= bee_pkg::DIM_W'(bee_pkg::MAX_HEIGHT))
              ? bee_pkg::DIM_W'(bee_pkg::MAX_HEIGHT) : bee_pkg::DIM_W'(r_frame_h);
        px_ext   = bee_pkg::DIM_W'(i_in_data.pos_x);
        py_ext   = bee_pkg::DIM_W'(i_in_data.pos_y);
        pos_addr = {py_ext[bee_pkg::Y_W-1:0], px_ext[bee_pkg::X_W-1:0]};
    end

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bee_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.opcode == bee_pkg::OP_PROCESS)
                            ? bee_pkg::ST_PROC : bee_pkg::ST_FINISH;
                end
            end
            bee_pkg::ST_PROC: begin
                if (proc_req.done) begin
                    n_state = bee_pkg::ST_FINISH;
                end
            end
            bee_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = bee_pkg::ST_IDLE;
                end
            end
            default: n_state = bee_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != bee_pkg::ST_IDLE);
        load_out   = (r_state == bee_pkg::ST_FINISH) && out_free;
        proc_start = in_accept && (i_in_data.opcode == bee_pkg::OP_PROCESS);
        solid_we   = in_accept && (i_in_data.opcode == bee_pkg::OP_WRITE)
                  && (px_ext < bee_pkg::DIM_W'(bee_pkg::MAX_WIDTH))
                  && (py_ext < bee_pkg::DIM_W'(bee_pkg::MAX_HEIGHT));
        edge_re    = proc_req.edge_re || (in_accept && (i_in_data.opcode == bee_pkg::OP_READ));
        edge_raddr = (r_state == bee_pkg::ST_PROC) ? proc_req.rd_addr : pos_addr;
        edge_we    = proc_req.edge_we;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bee_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_frame_w   <= bee_pkg::FRAME_WIDTH_RST;
            r_frame_h   <= bee_pkg::FRAME_HEIGHT_RST;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bee_pkg::CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data;
                    bee_pkg::CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data;
                    default:                   r_frame_w <= r_frame_w;
                endcase
            end
        end
        if (in_accept) begin
            r_op     <= i_in_data.opcode;
            r_inside <= (px_ext < eff_w) && (py_ext < eff_h);
        end
        if (load_out) begin
            r_out.edge_bit <= (r_op == bee_pkg::OP_READ) && r_inside && edge_rdata;
            r_out.done_res <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    bee_ram #(
        .WIDTH (1),
        .DEPTH (bee_pkg::DEPTH)
    ) u_solid_ram (
        .i_clk   (i_clk),
        .i_we    (solid_we),
        .i_waddr (pos_addr),
        .i_wdata (bee_pkg::is_solid(i_in_data.pixel_value)),
        .i_re    (proc_req.solid_re),
        .i_raddr (proc_req.rd_addr),
        .o_rdata (solid_rdata)
    );

    bee_ram #(
        .WIDTH (1),
        .DEPTH (bee_pkg::DEPTH)
    ) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (proc_req.wr_addr),
        .i_wdata (proc_req.wr_bit),
        .i_re    (edge_re),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    bee_proc u_proc (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (proc_start),
        .i_eff_w       (eff_w),
        .i_eff_h       (eff_h),
        .i_solid_rdata (solid_rdata),
        .i_edge_rdata  (edge_rdata),
        .o_req         (proc_req)
    );

    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, in_accept, r_state != bee_pkg::ST_IDLE, "accepted beat did not leave idle")
    `ASSERT_ALWAYS(a_edge_write_in_proc, i_clk, i_rst_n, !edge_we || (r_state == bee_pkg::ST_PROC), "edge store written outside processing")
    `ASSERT_ALWAYS(a_done_in_proc, i_clk, i_rst_n, !proc_req.done || (r_state == bee_pkg::ST_PROC), "sequencer finished while not processing")
    `ASSERT_ALWAYS(a_result_from_finish, i_clk, i_rst_n, !(r_out_valid && !$past(r_out_valid)) || ($past(r_state) == bee_pkg::ST_FINISH), "result loaded outside the finish state")

endmodule
